// ===== hdl/kbg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbg_pkg
// shared types and constants of the k-mer bias geometric-mean stream
// ----------------------------------------------------------------------------
package kbg_pkg;

    localparam logic       OP_WRITE  = 1'b0;
    localparam logic       OP_BASE   = 1'b1;
    localparam logic [2:0] BASE_NONE = 3'd4;
    localparam logic [31:0] ONE_Q16  = 32'd65536;

    typedef struct packed {
        logic        op;
        logic [2:0]  base_code;
        logic        seq_last;
        logic [19:0] entry_index;
        logic [31:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] bias_value;
        logic        run_last;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_qhead;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_RDF,
        ST_RDR,
        ST_MUL,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/kbg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbg_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module kbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kbg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbg_front
// input acceptance and two-entry queue towards the back end
// ----------------------------------------------------------------------------
module kbg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kbg_pkg::t_in_item i_data,
    input  logic              i_init_done,
    input  logic              i_pop,
    output kbg_pkg::t_qhead   o_head
);

    kbg_pkg::t_in_item r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = i_init_done && (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

endmodule

// ===== hdl/kbg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbg_back
// base window, table, per-position evaluation and integer square root
// ----------------------------------------------------------------------------
module kbg_back #(
    parameter int KMER_LEN  = 10,
    parameter int EDGE_SKIP = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kbg_pkg::t_qhead    i_head,
    output logic               o_pop,
    output logic               o_init_done,
    output logic               o_valid,
    input  logic               i_ready,
    output kbg_pkg::t_out_item o_data
);

    localparam int REV_END = 2 * KMER_LEN - EDGE_SKIP - 2;
    localparam int LAG     = (REV_END > EDGE_SKIP - 1) ? REV_END : (EDGE_SKIP - 1);
    localparam int HIST    = EDGE_SKIP + LAG + 1;
    localparam int AW      = 2 * KMER_LEN;
    localparam int KW      = $clog2(LAG + 1);
    localparam int ZLIM    = (EDGE_SKIP > KMER_LEN - EDGE_SKIP - 1) ?
                             EDGE_SKIP : (KMER_LEN - EDGE_SKIP - 1);

    kbg_pkg::t_state r_state;
    kbg_pkg::t_state n_state;

    logic [2:0]    r_win [HIST];
    logic [2:0]    r_wk  [HIST];
    logic [31:0]   r_cnt;
    logic [31:0]   r_n;
    logic          r_final;
    logic [KW-1:0] r_k;
    logic [AW-1:0] r_clr;

    logic [31:0]   r_pos;
    logic          r_zero;
    logic          r_last;
    logic          r_userev;
    logic [AW-1:0] r_fkey;
    logic [AW-1:0] r_rkey;
    logic          r_fbad;
    logic          r_rbad;
    logic [31:0]   r_f;
    logic [63:0]   r_v;
    logic [63:0]   r_root;
    logic [63:0]   r_bit;
    logic [4:0]    r_it;

    logic          r_ovalid;
    kbg_pkg::t_out_item r_out;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    logic [2:0]    code;
    logic [AW-1:0] fkey;
    logic [AW-1:0] rkey;
    logic          fbad;
    logic          rbad;
    logic [2:0]    fc;
    logic [2:0]    rc;
    logic [31:0]   pos;
    logic          out_free;
    logic          job_done;
    logic [63:0]   sq_t;
    logic [31:0]   rval;

    kbg_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign code = (i_head.item.base_code > kbg_pkg::BASE_NONE) ?
                  kbg_pkg::BASE_NONE : i_head.item.base_code;

    // k-mer keys from fixed taps of the work window
    always_comb begin
        fkey = '0;
        rkey = '0;
        fbad = 1'b0;
        rbad = 1'b0;
        fc   = '0;
        rc   = '0;
        for (int j = 0; j < KMER_LEN; j++) begin
            fc = r_wk[LAG + EDGE_SKIP - j];
            rc = r_wk[LAG - 2 * KMER_LEN + EDGE_SKIP + 2 + j];
            if (fc > 3'd3) begin
                fbad = 1'b1;
            end
            if (rc > 3'd3) begin
                rbad = 1'b1;
            end
            fkey = {fkey[AW-3:0], fc[1:0]};
            rkey = {rkey[AW-3:0], 2'd3 - rc[1:0]};
        end
    end

    assign pos      = r_n - {{(32-KW){1'b0}}, r_k};
    assign out_free = !r_ovalid || i_ready;
    assign job_done = !r_final || (r_k == '0);
    assign sq_t     = r_root + r_bit;
    assign rval     = r_rbad ? kbg_pkg::ONE_Q16 : ram_rdata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            kbg_pkg::ST_CLEAR: begin
                if (r_clr == {AW{1'b1}}) begin
                    n_state = kbg_pkg::ST_IDLE;
                end
            end
            kbg_pkg::ST_IDLE: begin
                if (i_head.valid && i_head.item.op == kbg_pkg::OP_BASE) begin
                    if (i_head.item.seq_last || r_cnt >= 32'(LAG)) begin
                        n_state = kbg_pkg::ST_EVAL;
                    end
                end
            end
            kbg_pkg::ST_EVAL: begin
                if ({{(32-KW){1'b0}}, r_k} <= r_n) begin
                    n_state = kbg_pkg::ST_RDF;
                end
            end
            kbg_pkg::ST_RDF:  n_state = kbg_pkg::ST_RDR;
            kbg_pkg::ST_RDR:  n_state = kbg_pkg::ST_MUL;
            kbg_pkg::ST_MUL:  n_state = kbg_pkg::ST_SQRT;
            kbg_pkg::ST_SQRT: begin
                if (r_it == 5'd31) begin
                    n_state = kbg_pkg::ST_OUT;
                end
            end
            kbg_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = job_done ? kbg_pkg::ST_IDLE : kbg_pkg::ST_EVAL;
                end
            end
            default: n_state = kbg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_fkey;
        ram_wdata = i_head.item.entry_value;
        o_pop     = 1'b0;
        case (r_state)
            kbg_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = kbg_pkg::ONE_Q16;
            end
            kbg_pkg::ST_IDLE: begin
                o_pop    = i_head.valid;
                ram_addr = AW'({{AW{1'b0}}, i_head.item.entry_index});
                ram_we   = i_head.valid && i_head.item.op == kbg_pkg::OP_WRITE;
            end
            kbg_pkg::ST_RDF: ram_addr = r_fkey;
            kbg_pkg::ST_RDR: ram_addr = r_rkey;
            default: begin
                ram_addr = r_fkey;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kbg_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < HIST; i++) begin
                r_win[i] <= kbg_pkg::BASE_NONE;
            end
        end else begin
            r_state <= n_state;
            if (r_state == kbg_pkg::ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                kbg_pkg::ST_CLEAR: r_clr <= r_clr + 1'b1;
                kbg_pkg::ST_IDLE: begin
                    if (i_head.valid && i_head.item.op == kbg_pkg::OP_BASE) begin
                        if (i_head.item.seq_last) begin
                            r_cnt <= '0;
                            for (int i = 0; i < HIST; i++) begin
                                r_win[i] <= kbg_pkg::BASE_NONE;
                            end
                        end else begin
                            r_cnt    <= r_cnt + 32'd1;
                            r_win[0] <= code;
                            for (int i = 1; i < HIST; i++) begin
                                r_win[i] <= r_win[i-1];
                            end
                        end
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            kbg_pkg::ST_IDLE: begin
                r_n     <= r_cnt;
                r_final <= i_head.item.seq_last;
                r_k     <= KW'(LAG);
                r_wk[0] <= code;
                for (int i = 1; i < HIST; i++) begin
                    r_wk[i] <= r_win[i-1];
                end
            end
            kbg_pkg::ST_EVAL: begin
                if ({{(32-KW){1'b0}}, r_k} <= r_n) begin
                    r_pos    <= pos;
                    r_zero   <= (pos < 32'(EDGE_SKIP)) ||
                                (r_final && (int'(r_k) < ZLIM));
                    r_userev <= !r_final || (int'(r_k) >= REV_END);
                    r_last   <= r_final && (r_k == '0);
                    r_fkey   <= fkey;
                    r_rkey   <= rkey;
                    r_fbad   <= fbad;
                    r_rbad   <= rbad;
                end else begin
                    r_k     <= r_k - 1'b1;
                    r_wk[0] <= kbg_pkg::BASE_NONE;
                    for (int i = 1; i < HIST; i++) begin
                        r_wk[i] <= r_wk[i-1];
                    end
                end
            end
            kbg_pkg::ST_RDR: begin
                r_f <= r_fbad ? kbg_pkg::ONE_Q16 : ram_rdata;
            end
            kbg_pkg::ST_MUL: begin
                r_v    <= {32'd0, r_f} * {32'd0, rval};
                r_root <= '0;
                r_bit  <= 64'd1 << 62;
                r_it   <= '0;
            end
            kbg_pkg::ST_SQRT: begin
                if (r_v >= sq_t) begin
                    r_v    <= r_v - sq_t;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_it  <= r_it + 5'd1;
            end
            kbg_pkg::ST_OUT: begin
                if (out_free) begin
                    r_out.position   <= r_pos;
                    r_out.bias_value <= r_zero ? 32'd0 :
                                        (r_userev ? r_root[31:0] : r_f);
                    r_out.run_last   <= r_last;
                    r_k              <= r_k - 1'b1;
                    r_wk[0]          <= kbg_pkg::BASE_NONE;
                    for (int i = 1; i < HIST; i++) begin
                        r_wk[i] <= r_wk[i-1];
                    end
                end
            end
            default: begin
                r_f <= r_f;
            end
        endcase
    end

    assign o_init_done = (r_state != kbg_pkg::ST_CLEAR);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

endmodule

// ===== hdl/kmer_bias_geomean_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_bias_geomean_stream
// k-mer bias table lookup with geometric mean of forward and reverse windows
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_ready  | i_data  (t_in_item)
//   output  | out       | o_valid / i_ready  | o_data  (t_out_item)
//
// a base that releases a position takes two table reads, one multiply and a
// 32-step root per result
// a final base walks up to LAG+1 positions, one result each
// after reset a clearing pass writes 1.0 to all 4^KMER_LEN table entries;
// no transaction is accepted until it ends
// a stalled output holds the back end; the front keeps a two-entry queue
// ----------------------------------------------------------------------------
module kmer_bias_geomean_stream #(
    parameter int KMER_LEN  = 10,
    parameter int EDGE_SKIP = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  kbg_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output kbg_pkg::t_out_item o_data
);

    kbg_pkg::t_qhead head;
    logic            pop;
    logic            init_done;

    kbg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_init_done (init_done),
        .i_pop       (pop),
        .o_head      (head)
    );

    kbg_back #(.KMER_LEN(KMER_LEN), .EDGE_SKIP(EDGE_SKIP)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_init_done (init_done),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== test/kmer_bias_geomean_stream_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_bias_geomean_stream_tb
// self-checking bench for the k-mer bias geometric-mean stream
//
// drives table writes and base sequences over the valid/ready input and
// checks every result against a local prediction of the combined bias.
// sequences are built first, and table entries are written for k-mers and
// reverse complements that really occur in them, so that lookups hit
// written entries as well as the 1.0 default. both sides idle in random
// bursts, except in the closing part of the run
// ----------------------------------------------------------------------------
module kmer_bias_geomean_stream_tb;
    import kbg_pkg::*;

    localparam int KLEN     = 10;
    localparam int SKIP     = 5;
    localparam int LAG_POS  = 2 * KLEN - SKIP - 2;
    localparam int WIN_LEN  = SKIP + LAG_POS + 1;
    localparam int WDOG_MAX = 3_000_000;

    class bias_scoreboard;
        bit [31:0]   tab [bit [19:0]];
        bit [2:0]    win [WIN_LEN];
        bit [31:0]   seen;
        t_out_item   pending [$];
        int          errors;
        int          checked;

        function new();
            foreach (win[k]) win[k] = BASE_NONE;
            seen = 0;
        endfunction

        function bit [31:0] lookup(bit [19:0] key);
            if (tab.exists(key)) return tab[key];
            return ONE_Q16;
        endfunction

        function bit [2:0] base_of(longint n, longint p, longint d);
            longint idx;
            idx = (n - p) - d;
            if (idx < 0 || idx >= WIN_LEN) return BASE_NONE;
            return win[idx];
        endfunction

        function bit [31:0] kmer_lookup(longint n, longint p, longint d0, bit rc);
            bit [19:0] key;
            bit [2:0]  c;
            key = 0;
            for (int j = 0; j < KLEN; j++) begin
                c = rc ? base_of(n, p, d0 + KLEN - 1 - j) : base_of(n, p, d0 + j);
                if (c > 3) return ONE_Q16;
                if (rc) c = 3 - c;
                key = {key[17:0], c[1:0]};
            end
            return lookup(key);
        endfunction

        function bit [31:0] root64(bit [63:0] v);
            bit [31:0] r;
            bit [31:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if (64'(t) * 64'(t) <= v) r = t;
            end
            return r;
        endfunction

        function bit [31:0] combined(longint n, longint p, longint lim);
            bit [31:0] f;
            longint rs;
            longint re;
            rs = p + KLEN - SKIP - 1;
            re = p + 2 * KLEN - SKIP - 2;
            if (p < SKIP || p + SKIP >= lim || rs >= lim) return 0;
            f = kmer_lookup(n, p, -SKIP, 0);
            if (rs >= 0 && re < lim)
                return root64(64'(f) * 64'(kmer_lookup(n, p, KLEN - SKIP - 1, 1)));
            return f;
        endfunction

        function void note_input(t_in_item it);
            t_out_item e;
            longint    n;
            longint    p0;
            if (it.op == OP_WRITE) begin
                tab[it.entry_index] = it.entry_value;
                return;
            end
            for (int k = WIN_LEN - 1; k > 0; k--) win[k] = win[k - 1];
            win[0] = (it.base_code > BASE_NONE) ? BASE_NONE : it.base_code;
            n = seen;
            if (!it.seq_last) begin
                seen++;
                if (n < LAG_POS) return;
                e.position   = 32'(n - LAG_POS);
                e.bias_value = combined(n, n - LAG_POS, longint'(1) << 62);
                e.run_last   = 1'b0;
                pending.push_back(e);
                return;
            end
            p0 = (n >= LAG_POS) ? n - LAG_POS : 0;
            for (longint p = p0; p <= n; p++) begin
                e.position   = 32'(p);
                e.bias_value = combined(n, p, n + 1);
                e.run_last   = (p == n);
                pending.push_back(e);
            end
            foreach (win[k]) win[k] = BASE_NONE;
            seen = 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result pos=%0d bias=%h last=%b",
                         $time, got.position, got.bias_value, got.run_last);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.position !== e.position) begin
                $display("%0t: position expected %0d actual %0d", $time, e.position,
                         got.position);
                errors++;
            end
            if (got.bias_value !== e.bias_value) begin
                $display("%0t: bias at pos %0d expected %h actual %h", $time,
                         e.position, e.bias_value, got.bias_value);
                errors++;
            end
            if (got.run_last !== e.run_last) begin
                $display("%0t: last flag at pos %0d expected %b actual %b", $time,
                         e.position, e.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    bias_scoreboard sb;
    bit  quiet;
    int  n_items;
    int  n_bases;
    int  n_writes;
    int  n_seqs;
    int  idle_cnt = 0;

    kmer_bias_geomean_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt == WDOG_MAX) begin
            $display("watchdog expired, %0d results still pending", sb.pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
        if (it.op == OP_WRITE) n_writes++;
        else n_bases++;
    endtask

    task automatic send_write(bit [19:0] idx, bit [31:0] val);
        t_in_item it;
        it.op          = OP_WRITE;
        it.base_code   = 3'($urandom);
        it.seq_last    = 1'($urandom);
        it.entry_index = idx;
        it.entry_value = val;
        send_item(it);
    endtask

    task automatic send_base(bit [2:0] code, bit last);
        t_in_item it;
        it.op          = OP_BASE;
        it.base_code   = code;
        it.seq_last    = last;
        it.entry_index = 20'($urandom);
        it.entry_value = $urandom;
        send_item(it);
    endtask

    function automatic bit [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return ONE_Q16;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_sequence(int len, int n_rate);
        bit [2:0]  seq [];
        bit [19:0] key;
        bit        ok;
        int        s;
        seq = new[len];
        foreach (seq[k]) begin
            seq[k] = ($urandom_range(0, 99) < n_rate) ? 3'($urandom_range(4, 7))
                                                       : 3'($urandom_range(0, 3));
        end
        if (len >= KLEN) begin
            repeat ($urandom_range(0, 4)) begin
                s   = $urandom_range(0, len - KLEN);
                key = 0;
                ok  = 1;
                if ($urandom_range(0, 1)) begin
                    for (int j = 0; j < KLEN; j++) begin
                        ok &= (seq[s + j] < 4);
                        key = {key[17:0], seq[s + j][1:0]};
                    end
                end else begin
                    for (int j = 0; j < KLEN; j++) begin
                        ok &= (seq[s + KLEN - 1 - j] < 4);
                        key = {key[17:0], 2'd3 - seq[s + KLEN - 1 - j][1:0]};
                    end
                end
                send_write(ok ? key : 20'($urandom), pick_value());
            end
        end
        foreach (seq[k]) begin
            if ($urandom_range(0, 30) == 0) send_write(20'($urandom), $urandom);
            send_base(seq[k], k == len - 1);
        end
        n_seqs++;
    endtask

    initial begin
        sb       = new();
        quiet    = 0;
        n_items  = 0;
        n_bases  = 0;
        n_writes = 0;
        n_seqs   = 0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single base, then codes above 4 only
        send_base(3'd2, 1'b1);
        send_base(3'd5, 1'b0);
        send_base(3'd6, 1'b0);
        send_base(3'd7, 1'b1);
        // extreme entries: all-A and its reverse complement all-T
        send_write(20'h00000, 32'hFFFF_FFFF);
        send_write(20'hFFFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 16; k++) send_base(3'd0, k == 15);
        send_write(20'hFFFFF, 32'h0);
        run_sequence(16, 0);

        while (n_items < 480) begin
            if (n_items > 420) quiet = 1;
            case ($urandom_range(0, 9))
                0:       run_sequence($urandom_range(1, 12), 10);
                1:       send_write(20'($urandom), $urandom);
                2:       run_sequence($urandom_range(30, 60), 3);
                default: run_sequence($urandom_range(12, 30), 4);
            endcase
        end
        quiet = 1;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d items sent: %0d bases in %0d sequences, %0d table writes",
                 n_items, n_bases, n_seqs, n_writes);
        $display("%0d results checked", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kbg_pkg.sv
hdl/kbg_ram.sv
hdl/kbg_front.sv
hdl/kbg_back.sv
hdl/kmer_bias_geomean_stream.sv
test/kmer_bias_geomean_stream_tb.sv
